// ----- hdl/afr_pkg.sv -----
// Shared types and constants for the accumulation frame buffer resolve block.
// No dependencies; every module file imports this package (afr_stream_if does not).
package afr_pkg;

  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_ACC     = 2'd1,
    OP_RAW     = 2'd2,
    OP_RESOLVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_SAMPLE_COUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_MODIFY,
    ST_RESOLVE,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DIV,
    PH_SQRT,
    PH_MUL,
    PH_SCALE
  } phase_t;

  localparam int CFG_DATA_W = 16;
  localparam logic [8:0]  FRAME_RST = 9'd256;
  localparam logic [15:0] COUNT_RST = 16'd1;
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [17:0] SCALE_MUL = 18'd255999;
  // ceil(2^28 / 1000): after a 16-bit shift, times this and >> 28 is / 65536000
  localparam logic [18:0] SCALE_RECIP = 19'd268436;

  typedef struct packed {
    op_t         opcode;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [23:0] sample_r;
    logic [23:0] sample_g;
    logic [23:0] sample_b;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] raw_r;
    logic [31:0] raw_g;
    logic [31:0] raw_b;
    logic [7:0]  pixel_r;
    logic [7:0]  pixel_g;
    logic [7:0]  pixel_b;
  } out_item_t;

  typedef struct packed {
    logic clr_en;
    logic in_load;
    logic addr_load;
    logic mem_rd;
    logic modify;
    logic res_start;
    logic out_load;
  } afr_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic oob;
    logic is_resolve;
    logic res_done;
    logic out_full;
  } afr_sts_t;

endpackage

// ----- hdl/afr_stream_if.sv -----
// Valid/ready stream channel carrying one payload of type T.
// Depends on nothing; payload types come from afr_pkg at the instance.
interface afr_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/afr_resolve_lane.sv -----
// One color channel of the resolve: divide by count, clamp, sqrt, scale to a byte.
// Iterative: 32 divide steps, 17 sqrt steps, one multiply, one reciprocal scale step.
// Uses afr_pkg.
module afr_resolve_lane (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] value,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [7:0]  pixel
);
  import afr_pkg::*;

  phase_t      phase_r;
  logic [4:0]  cnt_r;
  logic        done_r;
  logic [31:0] num_r;
  logic [15:0] rem_r;
  logic [15:0] div_r;
  logic [33:0] rad_r;
  logic [16:0] root_r;
  logic [19:0] srem_r;
  logic [34:0] prod_r;
  logic [7:0]  byte_r;

  logic [16:0] rem2;
  logic        div_ge;
  logic [31:0] num_nxt;
  logic [16:0] q_clamp;
  logic [19:0] srem2;
  logic [19:0] trial;
  logic [36:0] scale_prod;

  always_comb begin
    rem2    = {rem_r, num_r[31]};
    div_ge  = rem2 >= {1'b0, div_r};
    num_nxt = {num_r[30:0], div_ge};
    q_clamp = (num_nxt > 32'(ONE_Q16)) ? ONE_Q16 : num_nxt[16:0];
    srem2   = {srem_r[17:0], rad_r[33:32]};
    trial   = {1'b0, root_r, 2'b01};
    // product / 65536000 == (product >> 16) / 1000, done by reciprocal
    scale_prod = 37'(prod_r[34:16]) * 37'(SCALE_RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else if (start) begin
      phase_r <= PH_DIV;
      cnt_r   <= '0;
      done_r  <= 1'b0;
      num_r   <= value;
      rem_r   <= '0;
      div_r   <= divisor;
    end else begin
      case (phase_r)
        PH_DIV: begin
          num_r <= num_nxt;
          rem_r <= div_ge ? 16'(rem2 - {1'b0, div_r}) : rem2[15:0];
          if (cnt_r == 5'd31) begin
            // radicand is the clamped quotient in Q16.16, shifted up 16
            phase_r <= PH_SQRT;
            cnt_r   <= '0;
            rad_r   <= {1'b0, q_clamp, 16'h0000};
            root_r  <= '0;
            srem_r  <= '0;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        PH_SQRT: begin
          rad_r <= {rad_r[31:0], 2'b00};
          if (srem2 >= trial) begin
            srem_r <= srem2 - trial;
            root_r <= {root_r[15:0], 1'b1};
          end else begin
            srem_r <= srem2;
            root_r <= {root_r[15:0], 1'b0};
          end
          if (cnt_r == 5'd16) begin
            phase_r <= PH_MUL;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        PH_MUL: begin
          prod_r  <= 35'(root_r) * 35'(SCALE_MUL);
          byte_r  <= '0;
          phase_r <= PH_SCALE;
        end
        PH_SCALE: begin
          byte_r  <= scale_prod[35:28];
          phase_r <= PH_IDLE;
          done_r  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign done  = done_r;
  assign pixel = byte_r;

endmodule

// ----- hdl/afr_ctrl.sv -----
// Sequencer for the frame buffer: clear sweep, address, read, modify, resolve, emit.
// Drives afr_cmd_t to the datapath and reads afr_sts_t back. Uses afr_pkg.
module afr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  afr_pkg::afr_sts_t sts,
  output afr_pkg::afr_cmd_t cmd
);
  import afr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.addr_load = 1'b1;
        state_nxt     = sts.oob ? ST_EMIT : ST_READ;
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_MODIFY;
      end
      ST_MODIFY: begin
        cmd.modify = 1'b1;
        if (sts.is_resolve) begin
          cmd.res_start = 1'b1;
          state_nxt     = ST_RESOLVE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_RESOLVE: begin
        if (sts.res_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_resolve_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESOLVE) |-> ($past(state_r) == ST_MODIFY || $past(state_r) == ST_RESOLVE))
    else $error("resolve wait entered from wrong state");

endmodule

// ----- hdl/afr_dp.sv -----
// Datapath: config registers, 96-bit pixel store, read-modify-write, resolve lanes
// and the output register. Controlled by afr_ctrl through afr_cmd_t. Uses afr_pkg.
module afr_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  afr_pkg::cfg_idx_t          cfg_index,
  input  logic [afr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  afr_pkg::in_item_t          in_data,
  input  logic                       out_ready,
  output logic                       out_valid,
  output afr_pkg::out_item_t         out_data,
  input  afr_pkg::afr_cmd_t          cmd,
  output afr_pkg::afr_sts_t          sts
);
  import afr_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
  localparam int DH    = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
  localparam int LW    = ((AW > 9 + DW) ? AW : 9 + DW) + 1;

  logic [8:0]  frame_width_r;
  logic [8:0]  frame_height_r;
  logic [15:0] sample_count_r;

  in_item_t    item_r;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] clr_addr_r;
  logic        oob_r;
  logic [95:0] rd_r;
  logic [95:0] raw_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   out_data_nxt;

  logic [95:0] mem [DEPTH];

  logic [DW-1:0] w_eff;
  logic [DH-1:0] h_eff;
  logic          oob;
  logic [LW-1:0] lin;
  logic [95:0]   new_word;
  logic [31:0]   old_ch [3];
  logic [23:0]   smp_ch [3];
  logic [31:0]   new_ch [3];
  logic [32:0]   sum_ch [3];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [95:0]   mem_wd;
  logic [15:0]   n_eff;
  logic [2:0]    lane_done;
  logic [7:0]    lane_pix [3];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_RST;
      frame_height_r <= FRAME_RST;
      sample_count_r <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[8:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[8:0];
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // address and range check
  always_comb begin
    w_eff = (DW'(frame_width_r) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(frame_width_r);
    h_eff = (DH'(frame_height_r) > DH'(MAX_HEIGHT)) ? DH'(MAX_HEIGHT) : DH'(frame_height_r);
    oob   = (DW'(item_r.pos_x) >= w_eff) || (DH'(item_r.pos_y) >= h_eff);
    lin   = LW'(item_r.pos_y) * LW'(w_eff) + LW'(item_r.pos_x);
    n_eff = (sample_count_r == 16'd0) ? 16'd1 : sample_count_r;
  end

  // per-channel modify
  always_comb begin
    old_ch[0] = rd_r[95:64];
    old_ch[1] = rd_r[63:32];
    old_ch[2] = rd_r[31:0];
    smp_ch[0] = item_r.sample_r;
    smp_ch[1] = item_r.sample_g;
    smp_ch[2] = item_r.sample_b;
    for (int c = 0; c < 3; c++) begin
      sum_ch[c] = {1'b0, old_ch[c]} + 33'(smp_ch[c]);
      case (item_r.opcode)
        OP_SET:  new_ch[c] = 32'(smp_ch[c]);
        OP_ACC:  new_ch[c] = sum_ch[c][32] ? 32'hFFFF_FFFF : sum_ch[c][31:0];
        default: new_ch[c] = old_ch[c];
      endcase
    end
    new_word = {new_ch[0], new_ch[1], new_ch[2]};
  end

  assign mem_we = cmd.clr_en ||
                  (cmd.modify && (item_r.opcode == OP_SET || item_r.opcode == OP_ACC));
  assign mem_wa = cmd.clr_en ? clr_addr_r : addr_r;
  assign mem_wd = cmd.clr_en ? '0 : new_word;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.mem_rd) rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr_en) clr_addr_r <= clr_addr_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) item_r <= in_data;
    if (cmd.addr_load) begin
      addr_r <= lin[AW-1:0];
      oob_r  <= oob;
    end
    if (cmd.modify) raw_r <= new_word;
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    afr_resolve_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (cmd.res_start),
      .value   (new_ch[c]),
      .divisor (n_eff),
      .done    (lane_done[c]),
      .pixel   (lane_pix[c])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    if (oob_r) begin
      out_data_nxt.status = 1'b1;
    end else begin
      out_data_nxt.raw_r = raw_r[95:64];
      out_data_nxt.raw_g = raw_r[63:32];
      out_data_nxt.raw_b = raw_r[31:0];
      if (item_r.opcode == OP_RESOLVE) begin
        out_data_nxt.pixel_r = lane_pix[0];
        out_data_nxt.pixel_g = lane_pix[1];
        out_data_nxt.pixel_b = lane_pix[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.clr_last   = clr_addr_r == AW'(DEPTH - 1);
  assign sts.oob        = oob;
  assign sts.is_resolve = item_r.opcode == OP_RESOLVE;
  assign sts.res_done   = &lane_done;
  assign sts.out_full   = out_valid_r && !out_ready;

  a_no_write_oob: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.modify |-> !oob_r)
    else $error("store modified for an out-of-range coordinate");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result load did not raise valid");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before transfer");

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
    else $error("resolve lanes out of step");

endmodule

// ----- hdl/accumulation_framebuffer_resolve.sv -----
// Top level of the accumulation frame buffer with gamma-2 resolve.
// Instantiates afr_ctrl and afr_dp; uses afr_pkg and afr_stream_if.
//
//   channel   dir   payload      transfer when
//   in_chan   in    in_item_t    in_chan.valid && in_chan.ready
//   out_chan  out   out_item_t   out_chan.valid && out_chan.ready
//   cfg_*     in    16-bit data  cfg_we high (index 0 width, 1 height, 2 count)
//
// Flow: an out-of-range item skips from address to emit; set, accumulate and raw
//   read go address, read, modify, emit; resolve adds the 32-step divider and
//   17-step sqrt of each lane (three side by side), one multiply, one scale step.
// Reset: synchronous, active low; then, with in_chan not ready, a sweep clears
//   the store one entry per clock, all MAX_WIDTH*MAX_HEIGHT (65536 by default).
// Stalls: one item is in flight at a time; the output register holds a finished
//   result while the next item is taken and worked on. If that result is still
//   not taken when the next one is ready, the sequencer waits and in_chan stalls.
module accumulation_framebuffer_resolve #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  afr_stream_if.sink                     in_chan,
  afr_stream_if.source                   out_chan,
  input  logic                           cfg_we,
  input  afr_pkg::cfg_idx_t              cfg_index,
  input  logic [afr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import afr_pkg::*;

  afr_cmd_t  cmd;
  afr_sts_t  sts;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  // sequencer: one item at a time, store clear after reset
  afr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, arithmetic and result register
  afr_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_chan.data),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign out_chan.data  = out_data;

endmodule
